### rtl/minimum_covering_window_macros.svh
// Assertion macros for the minimum covering window design, included by the back part.
`ifndef MINIMUM_COVERING_WINDOW_MACROS_SVH
`define MINIMUM_COVERING_WINDOW_MACROS_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define MCW_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define MCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mcw_pkg.sv
// Types, register codes and the pattern classifier of the minimum covering window block.
package mcw_pkg;

    // Register indexes of the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd1;
    localparam int CFG_DATA_W = 64;
    localparam int MAX_SLOTS = 8;

    typedef struct packed {
        logic [7:0] text_char;
        logic       text_end;
    } t_in_req;

    typedef struct packed {
        logic        window_found;
        logic [9:0]  best_start;
        logic [10:0] best_length;
        logic        buffer_overflow;
        logic        final_result;
    } t_result;

    // Pattern as seen by the datapath; length is already saturated to the slot count
    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  length;
    } t_pattern;

    // Classification of one byte against the pattern
    typedef struct packed {
        logic       hit;
        logic [2:0] slot;
        logic [3:0] need;
    } t_class;

    typedef struct packed {
        t_in_req req;
        t_class  cls;
    } t_mid_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SHRINK,
        BK_FINISH
    } t_back_state;

    // Find the lowest valid slot holding c and count its copies in the pattern
    function automatic t_class classify(t_pattern pat, logic [7:0] c);
        t_class r;
        r = '0;
        for (int s = MAX_SLOTS - 1; s >= 0; s--) begin
            if ((4'(s) < pat.length) && (pat.bytes[8*s +: 8] == c)) begin
                r.hit  = 1'b1;
                r.slot = 3'(s);
                r.need = r.need + 4'd1;
            end
        end
        return r;
    endfunction

endpackage

### rtl/minimum_covering_window.sv
// Top level of the minimum covering window block: registers, queues, front and back parts.
//
// Text bytes enter through a queue-style port: a request is taken at a clock edge with
// push high and full low. Each byte yields one result, read from a queue-style port:
// the oldest result sits on o_result while empty is low and leaves on pop with empty low.
// Each result carries the best (shortest, earliest) covering window so far, the overflow
// flag, and final_result on the result of the byte marked text_end; after that byte all
// text state clears. The user must write the pattern registers through i_cfg_we /
// i_cfg_index / i_cfg_data only while the block is idle; the block itself does not
// enforce this. A write clears the text state as well. A byte's result passes the
// front register, the middle queue, the back part's store step, optional shrink steps
// that move the left pointer until the byte under it is still needed, and the report
// step. The back part takes no new byte before it reports the last one. Each stored byte
// is dropped by the left pointer at most once; the shrink uses the store's single read port.
// Reset clears all control state and the registers; the text store needs no clearing.
// When the receiver stalls, the two-entry result queue fills, the back part holds in its
// report step, then the middle queue and front register fill and full rises.
module minimum_covering_window #(
    parameter int TEXT_DEPTH    = 1024,
    parameter int PATTERN_SLOTS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    input  mcw_pkg::t_in_req                  i_in_req,
    output logic                              full,
    input  logic                              pop,
    output mcw_pkg::t_result                  o_result,
    output logic                              empty,
    input  logic                              i_cfg_we,
    input  logic [mcw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mcw_pkg::*;

    logic [63:0] r_pat_bytes, n_pat_bytes;
    logic [3:0]  r_pat_len, n_pat_len;
    logic        cfg_clear;
    t_pattern    pat;

    logic        mid_push;
    logic        mid_full;
    logic        mid_pop;
    logic        mid_empty;
    t_mid_item   mid_in;
    t_mid_item   mid_out;
    logic        out_push;
    logic        out_full;
    t_result     out_in;

    // Decode register writes
    always_comb begin
        n_pat_bytes = r_pat_bytes;
        n_pat_len   = r_pat_len;
        cfg_clear   = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PATTERN_BYTES: begin
                    n_pat_bytes = i_cfg_data;
                    cfg_clear   = 1'b1;
                end
                CFG_PATTERN_LENGTH: begin
                    n_pat_len = i_cfg_data[3:0];
                    cfg_clear = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
        end else begin
            r_pat_bytes <= n_pat_bytes;
            r_pat_len   <= n_pat_len;
        end
    end

    // Saturate the pattern length to the slot count
    assign pat.bytes  = r_pat_bytes;
    assign pat.length = (r_pat_len > 4'(PATTERN_SLOTS)) ? 4'(PATTERN_SLOTS) : r_pat_len;

    mcw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pat      (pat),
        .i_push     (push),
        .i_req      (i_in_req),
        .o_full     (full),
        .o_mid_push (mid_push),
        .o_mid_item (mid_in),
        .i_mid_full (mid_full)
    );

    mcw_fifo #(
        .WIDTH ($bits(t_mid_item)),
        .DEPTH (2)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_wdata (mid_in),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_rdata (mid_out),
        .o_empty (mid_empty)
    );

    mcw_back #(
        .TEXT_DEPTH    (TEXT_DEPTH),
        .PATTERN_SLOTS (PATTERN_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pat       (pat),
        .i_clear     (cfg_clear),
        .i_mid_empty (mid_empty),
        .o_mid_pop   (mid_pop),
        .i_mid_item  (mid_out),
        .i_out_full  (out_full),
        .o_out_push  (out_push),
        .o_out_data  (out_in)
    );

    mcw_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_wdata (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_rdata (o_result),
        .o_empty (empty)
    );

endmodule

### rtl/mcw_fifo.sv
// Small register FIFO used between the front and back parts and on the result side.
module mcw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        n_count = r_count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store the pushed request
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

### rtl/mcw_ram.sv
// Generic simple dual-port RAM with registered read.
module mcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

endmodule

### rtl/mcw_front.sv
// Front part: accepts text bytes, classifies them against the pattern, feeds the queue.
module mcw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcw_pkg::t_pattern   i_pat,
    input  logic                i_push,
    input  mcw_pkg::t_in_req    i_req,
    output logic                o_full,
    output logic                o_mid_push,
    output mcw_pkg::t_mid_item  o_mid_item,
    input  logic                i_mid_full
);
    import mcw_pkg::*;

    logic      r_valid, n_valid;
    t_mid_item r_item, n_item;
    logic      accept;

    assign o_full     = r_valid && i_mid_full;
    assign accept     = i_push && !o_full;
    assign o_mid_push = r_valid;
    assign o_mid_item = r_item;

    // Capture and classify a new request, drop the held one once the queue takes it
    always_comb begin
        n_valid = r_valid;
        n_item  = r_item;
        if (r_valid && !i_mid_full) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid    = 1'b1;
            n_item.req = i_req;
            n_item.cls = classify(i_pat, i_req.text_char);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

### rtl/mcw_back.sv
// Back part: stores the text, keeps slot counts, moves the left pointer and reports the best window.
`include "minimum_covering_window_macros.svh"
module mcw_back #(
    parameter int TEXT_DEPTH    = 1024,
    parameter int PATTERN_SLOTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcw_pkg::t_pattern   i_pat,
    input  logic                i_clear,
    input  logic                i_mid_empty,
    output logic                o_mid_pop,
    input  mcw_pkg::t_mid_item  i_mid_item,
    input  logic                i_out_full,
    output logic                o_out_push,
    output mcw_pkg::t_result    o_out_data
);
    import mcw_pkg::*;

    localparam int AW = $clog2(TEXT_DEPTH);
    localparam int CW = AW + 1;
    localparam int SW = (PATTERN_SLOTS > 1) ? $clog2(PATTERN_SLOTS) : 1;

    t_back_state   r_state, n_state;
    logic [CW-1:0] r_counts [PATTERN_SLOTS];
    logic [CW-1:0] n_counts [PATTERN_SLOTS];
    logic [3:0]    r_cov, n_cov;
    logic [AW-1:0] r_left, n_left;
    logic [CW-1:0] r_wpos, n_wpos;
    logic [AW-1:0] r_best_begin, n_best_begin;
    logic [CW-1:0] r_best_span, n_best_span;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_pos, n_pos;
    logic          r_cover, n_cover;
    logic          r_last, n_last;

    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    t_class        in_cls;
    t_class        rd_cls;
    logic [SW-1:0] in_idx;
    logic [SW-1:0] rd_idx;
    logic          in_room;
    logic [CW-1:0] cnt_inc;
    logic [3:0]    cov_new;
    logic          cover_now;
    logic          enter_shrink;
    logic          shrink_step;
    logic [AW-1:0] left_inc;
    logic          more;
    logic [CW-1:0] span_len;

    mcw_ram #(
        .WIDTH (8),
        .DEPTH (TEXT_DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos[AW-1:0]),
        .i_wdata (i_mid_item.req.text_char),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Take the incoming byte's class from the front part and classify the byte under the left pointer
    assign in_cls   = i_mid_item.cls;
    assign in_idx   = in_cls.slot[SW-1:0];
    assign rd_cls   = classify(i_pat, ram_rdata);
    assign rd_idx   = rd_cls.slot[SW-1:0];
    assign in_room  = (r_wpos < CW'(TEXT_DEPTH));
    assign cnt_inc  = r_counts[in_idx] + 1'b1;
    assign cov_new  = (in_cls.hit && (cnt_inc <= CW'(in_cls.need))) ? r_cov + 4'd1 : r_cov;
    assign cover_now    = in_room && (i_pat.length != '0) && (cov_new == i_pat.length);
    assign enter_shrink = cover_now && (r_left < r_wpos[AW-1:0]);
    assign shrink_step  = !rd_cls.hit || (r_counts[rd_idx] > CW'(rd_cls.need));
    assign left_inc     = r_left + 1'b1;
    assign more         = (left_inc < r_pos);
    assign span_len     = CW'(r_pos) - CW'(r_left) + 1'b1;

    // Sequence one request: store, shrink, report
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_mid_empty) begin
                    n_state = enter_shrink ? BK_SHRINK : BK_FINISH;
                end
            end
            BK_SHRINK: begin
                if (!shrink_step || !more) begin
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (!i_out_full) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Datapath and handshake outputs
    always_comb begin
        n_counts     = r_counts;
        n_cov        = r_cov;
        n_left       = r_left;
        n_wpos       = r_wpos;
        n_best_begin = r_best_begin;
        n_best_span  = r_best_span;
        n_ovf        = r_ovf;
        n_pos        = r_pos;
        n_cover      = r_cover;
        n_last       = r_last;
        ram_we       = 1'b0;
        ram_raddr    = r_left;
        o_mid_pop    = 1'b0;
        o_out_push   = 1'b0;
        o_out_data   = '0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_mid_empty) begin
                    o_mid_pop = 1'b1;
                    n_pos     = r_wpos[AW-1:0];
                    n_last    = i_mid_item.req.text_end;
                    n_cover   = cover_now;
                    if (in_room) begin
                        ram_we = 1'b1;
                        n_wpos = r_wpos + 1'b1;
                        n_cov  = cov_new;
                        if (in_cls.hit) begin
                            n_counts[in_idx] = cnt_inc;
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            BK_SHRINK: begin
                // Drop a non-pattern or surplus byte and fetch the next one
                if (shrink_step) begin
                    n_left    = left_inc;
                    ram_raddr = left_inc;
                    if (rd_cls.hit) begin
                        n_counts[rd_idx] = r_counts[rd_idx] - 1'b1;
                    end
                end
            end
            BK_FINISH: begin
                if (r_cover && ((r_best_span == '0) || (span_len < r_best_span))) begin
                    n_best_span  = span_len;
                    n_best_begin = r_left;
                end
                o_out_data.window_found    = (n_best_span != '0);
                o_out_data.best_start      = 10'(n_best_begin);
                o_out_data.best_length     = 11'(n_best_span);
                o_out_data.buffer_overflow = r_ovf;
                o_out_data.final_result    = r_last;
                if (!i_out_full) begin
                    o_out_push = 1'b1;
                    if (r_last) begin
                        n_counts     = '{default: '0};
                        n_cov        = '0;
                        n_left       = '0;
                        n_wpos       = '0;
                        n_best_begin = '0;
                        n_best_span  = '0;
                        n_ovf        = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        // Clear text state on a register write
        if (i_clear) begin
            n_counts     = '{default: '0};
            n_cov        = '0;
            n_left       = '0;
            n_wpos       = '0;
            n_best_begin = '0;
            n_best_span  = '0;
            n_ovf        = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= BK_IDLE;
            r_counts     <= '{default: '0};
            r_cov        <= '0;
            r_left       <= '0;
            r_wpos       <= '0;
            r_best_begin <= '0;
            r_best_span  <= '0;
            r_ovf        <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_counts     <= n_counts;
            r_cov        <= n_cov;
            r_left       <= n_left;
            r_wpos       <= n_wpos;
            r_best_begin <= n_best_begin;
            r_best_span  <= n_best_span;
            r_ovf        <= n_ovf;
        end
    end

    // Per-request working values
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_cover <= n_cover;
        r_last  <= n_last;
    end

    `MCW_ASSERT(a_left_behind_write, 1'b1, CW'(r_left) <= r_wpos, "left pointer passed write position")
    `MCW_ASSERT(a_cov_bound, 1'b1, r_cov <= i_pat.length, "covered count above pattern length")
    `MCW_ASSERT(a_shrink_range, r_state == BK_SHRINK, r_left < r_pos, "shrink past newest byte")
    `MCW_ASSERT_NEXT(a_pop_starts_work, o_mid_pop, r_state != BK_IDLE, "request popped but not worked")

endmodule
